>>> src/svc_pkg.sv
// shared types and constants for the sparse vector clock store
package svc_pkg;

  // field widths
  localparam int IDX_W = 8;
  localparam int VAL_W = 64;
  localparam int CNT_W = 9;

  // stream payload widths; the data widths are padded to whole bytes
  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 88;
  localparam int OUT_PAD_W  = OUT_DATA_W - (VAL_W + IDX_W + CNT_W + 2);

  // operation codes
  typedef enum logic [1:0] {
    OP_GET       = 2'd0,
    OP_RAISE     = 2'd1,
    OP_CLEAR     = 2'd2,
    OP_READ_LIST = 2'd3
  } op_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;  // item accepted: latch it and start the first memory read
    logic lookup;   // read the counter of the thread fetched from the list
    logic finish;   // commit state updates and load the result register
  } svc_cmd_t;

endpackage

>>> src/svc_ctrl.sv
// controller: sequences each item and owns the handshake flags
module svc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  svc_pkg::op_t        op,
  input  logic                m_tready,
  output logic                s_tready,
  output logic                m_tvalid,
  output svc_pkg::svc_cmd_t   cmd
);
  import svc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EXEC
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   slot_free;

  // handshake and command decode
  assign s_tready    = (state == ST_IDLE);
  assign accept      = s_tvalid && s_tready;
  assign slot_free   = !m_tvalid || m_tready;
  assign cmd.capture = accept;
  assign cmd.lookup  = (state == ST_LOOKUP);
  assign cmd.finish  = (state == ST_EXEC) && slot_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (op == OP_READ_LIST) ? ST_LOOKUP : ST_EXEC;
        end
      end
      ST_LOOKUP: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

>>> src/svc_datapath.sv
// datapath: counter, list and mark storage plus result formation
module svc_datapath #(
  parameter int THREADS = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  svc_pkg::svc_cmd_t                 cmd,
  input  logic [svc_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [svc_pkg::IN_USER_W-1:0]     s_tuser,
  output logic [svc_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import svc_pkg::*;

  // only thread indexes below MEM_DEPTH (THREADS, at most 256) can be addressed
  localparam int MEM_DEPTH = (THREADS < 256) ? THREADS : 256;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MEM_DEPTH);

  // latched item
  op_t              op_q;
  logic [IDX_W-1:0] idx_q;
  logic [VAL_W-1:0] val_q;

  // storage; a counter is only meaningful while its mark is set
  logic [VAL_W-1:0] cnt_mem  [MEM_DEPTH];
  logic [IDX_W-1:0] list_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] marks;
  logic [CNT_W-1:0]     list_len;

  // registered read data
  logic [VAL_W-1:0] rd_cnt;
  logic             rd_mark;
  logic [IDX_W-1:0] rd_list;

  // result register
  logic [VAL_W-1:0] res_cval;
  logic [IDX_W-1:0] res_listed;
  logic [CNT_W-1:0] res_count;
  logic             res_chg;
  logic             res_bad;

  logic [IDX_W-1:0] in_idx;
  logic [VAL_W-1:0] in_val;
  logic [AW-1:0]    rd_addr;
  logic             in_range;
  logic [VAL_W-1:0] cur;
  logic             larger;
  logic             raise_hit;
  logic             raise_append;
  logic             wr_en;
  logic             append;
  logic             bad;
  logic [VAL_W-1:0] cval;
  logic [IDX_W-1:0] listed;
  logic [CNT_W-1:0] count;

  assign in_idx = s_tdata[IDX_W-1:0];
  assign in_val = s_tdata[IDX_W+VAL_W-1:IDX_W];

  // counter read port address: item thread, or thread taken from the list
  assign rd_addr = cmd.lookup ? rd_list[AW-1:0] : in_idx[AW-1:0];

  // compare and update decisions
  assign in_range     = ({1'b0, idx_q} < LIMIT);
  assign cur          = rd_mark ? rd_cnt : '0;
  assign larger       = (cur < val_q);
  assign raise_hit    = (op_q == OP_RAISE) && in_range && larger;
  assign raise_append = raise_hit && !rd_mark && (list_len < LIMIT);
  assign wr_en        = cmd.finish && raise_hit;
  assign append       = cmd.finish && raise_append;
  assign bad          = ({1'b0, idx_q} >= list_len);

  // result per operation
  always_comb begin
    cval   = '0;
    listed = '0;
    count  = list_len;
    case (op_q)
      OP_GET: begin
        cval = in_range ? cur : '0;
      end
      OP_RAISE: begin
        if (in_range) begin
          cval = larger ? val_q : cur;
        end
        count = list_len + CNT_W'(raise_append);
      end
      OP_CLEAR: begin
        count = '0;
      end
      OP_READ_LIST: begin
        if (!bad) begin
          cval   = cur;
          listed = rd_list;
        end
      end
      default: begin
        cval = '0;
      end
    endcase
  end

  // item latch, memories and result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= op_t'(s_tuser);
      idx_q   <= in_idx;
      val_q   <= in_val;
      rd_list <= list_mem[in_idx[AW-1:0]];
    end
    if (cmd.capture || cmd.lookup) begin
      rd_cnt  <= cnt_mem[rd_addr];
      rd_mark <= marks[rd_addr];
    end
    if (wr_en) begin
      cnt_mem[idx_q[AW-1:0]] <= val_q;
    end
    if (append) begin
      list_mem[list_len[AW-1:0]] <= idx_q;
    end
    if (cmd.finish) begin
      res_cval   <= cval;
      res_listed <= listed;
      res_count  <= count;
      res_chg    <= raise_hit;
      res_bad    <= (op_q == OP_READ_LIST) && bad;
    end
  end

  // marks and list length; clearing the marks empties the whole clock
  always_ff @(posedge clk) begin
    if (rst) begin
      marks    <= '0;
      list_len <= '0;
    end else if (cmd.finish) begin
      if (op_q == OP_CLEAR) begin
        marks    <= '0;
        list_len <= '0;
      end else if (raise_append) begin
        marks[idx_q[AW-1:0]] <= 1'b1;
        list_len             <= list_len + CNT_W'(1);
      end
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, res_bad, res_chg, res_count, res_listed, res_cval};

endmodule

>>> src/sparse_vector_clock_store.sv
// top level of the sparse vector clock store
// order: get, raise and clear read the counter memory when the item is accepted, then load
//   the result register once the output slot is free; a list read reads the list memory,
//   then the counter memory; one item at a time: the next item is taken only
//   once the result sits in the output register, which may still wait for m_axis_tready
// reset: clears touched marks, list length and output valid; counters need no sweep
//   since an unmarked counter reads as zero
module sparse_vector_clock_store #(
  parameter int THREADS = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // thread_index[7:0], new_value[71:8]
  input  logic [svc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // operation[1:0]
  input  logic [svc_pkg::IN_USER_W-1:0]     s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // counter_value[63:0], listed_thread[71:64], touched_count[80:72],
  // changed[81], bad_position[82], zero[87:83]
  output logic [svc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import svc_pkg::*;

  svc_cmd_t cmd;

  // controller
  svc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .op       (op_t'(s_axis_tuser)),
    .m_tready (m_axis_tready),
    .s_tready (s_axis_tready),
    .m_tvalid (m_axis_tvalid),
    .cmd      (cmd)
  );

  // datapath
  svc_datapath #(
    .THREADS (THREADS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_tdata (s_axis_tdata),
    .s_tuser (s_axis_tuser),
    .m_tdata (m_axis_tdata)
  );

endmodule

>>> src/svc_checker.sv
// port-level checks of the sparse vector clock store, bound to the top level
module svc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [svc_pkg::IN_USER_W-1:0]     s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [svc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import svc_pkg::*;

  // no result is offered right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // one item at a time: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after an accept");

  // a short operation accepted with a free output slot passes the execute state and then shows its result
  a_short_latency: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && !m_axis_tvalid && s_axis_tuser != OP_READ_LIST)
      |=> ##1 m_axis_tvalid)
    else $error("result missing after short operation");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind sparse_vector_clock_store svc_checker u_svc_checker (.*);
